// ===== src/assert_macros.svh =====
// Assertion macros for the RTL of the slot allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define FSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define FSL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fsl_pkg.sv =====
// Package with types and constants of the fixed slot free-list allocator.
`timescale 1ns / 1ps

package fsl_pkg;

  localparam int SlotCount = 128;
  localparam int SlotBytes = 4;
  localparam int SlotW     = $clog2(SlotCount);
  localparam int BumpW     = SlotW + 1;
  localparam int LinkW     = SlotW + 1;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [1:0] STAT_NO_SLOTS  = 2'd2;
  localparam logic [1:0] STAT_BAD_SLOT  = 2'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] request_size;
    logic [6:0] free_slot;
  } fsl_req_t;

  typedef struct packed {
    logic [6:0] granted_slot;
    logic [1:0] status;
    logic       list_empty;
  } fsl_rsp_t;

endpackage

// ===== src/fsl_link_ram.sv =====
// Single-port-write, registered-read RAM holding the free-list links.
`timescale 1ns / 1ps

module fsl_link_ram #(
  parameter int Depth = 128,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fixed_slot_free_list_allocator_unit.sv =====
// Top level of the fixed slot free-list allocator.
// Timing: the accepting edge loads the request, starts the head read and enters the resolve
// state; the result and its strobe are registered at the end of the resolve cycle.
// A new transaction is not accepted until the previous one is resolved; busy stays high for one
// cycle, the resolve cycle, in which the registered read of the list head's link is used.
// Reset: free list empty, bump counter zero; the link RAM is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_slot_free_list_allocator_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fsl_pkg::fsl_req_t req_i,
  output logic             result_valid_o,
  output fsl_pkg::fsl_rsp_t rsp_o
);

  import fsl_pkg::*;

  // Sequencer codes: wait for a transaction, then resolve it.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_q, state_d;
  fsl_req_t         item_q;
  logic [SlotW-1:0] head_q, head_d;
  logic             head_valid_q, head_valid_d;
  logic [BumpW-1:0] bump_q, bump_d;
  fsl_rsp_t         rsp_q, rsp_d;
  logic             rsp_valid_q;

  logic             accept;
  logic             link_we;
  logic [SlotW-1:0] link_waddr;
  logic [LinkW-1:0] link_wdata;
  logic [LinkW-1:0] link_rdata;

  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;

  // Link RAM: each entry is {next valid, next index}. Read the current head on
  // accept so its link is ready in the resolve cycle; writes only happen while
  // busy, so a read and a write never meet on the same edge.
  fsl_link_ram #(
    .Depth (SlotCount),
    .Width (LinkW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (link_rdata)
  );

  // Resolve the held transaction against the list head and bump counter.
  always_comb begin
    head_d       = head_q;
    head_valid_d = head_valid_q;
    bump_d       = bump_q;
    link_we      = 1'b0;
    link_waddr   = item_q.free_slot[SlotW-1:0];
    link_wdata   = {head_valid_q, head_q};
    rsp_d        = '0;
    rsp_d.status = STAT_OK;

    if (item_q.action == ACT_ALLOC) begin
      priority if (item_q.request_size > 8'(SlotBytes)) begin
        rsp_d.status = STAT_TOO_LARGE;
      end else if (head_valid_q) begin
        // Pop: hand out the head, advance to its stored link.
        rsp_d.granted_slot = 7'(head_q);
        head_d             = link_rdata[SlotW-1:0];
        head_valid_d       = link_rdata[LinkW-1];
      end else if (bump_q < BumpW'(SlotCount)) begin
        // List empty: take the next never-used slot.
        rsp_d.granted_slot = 7'(bump_q[SlotW-1:0]);
        bump_d             = bump_q + BumpW'(1);
      end else begin
        rsp_d.status = STAT_NO_SLOTS;
      end
    end else begin
      if (BumpW'(item_q.free_slot) >= bump_q) begin
        rsp_d.status = STAT_BAD_SLOT;
      end else begin
        // Push: link the old head behind the returned slot, in the resolve cycle only.
        link_we      = busy;
        head_d       = item_q.free_slot[SlotW-1:0];
        head_valid_d = 1'b1;
      end
    end

    rsp_d.list_empty = !head_valid_d;
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      bump_q       <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= busy;
      if (busy) begin
        head_q       <= head_d;
        head_valid_q <= head_valid_d;
        bump_q       <= bump_d;
      end
    end
  end

  // Payload registers: hold the accepted transaction and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i;
    end
    if (busy) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = rsp_valid_q;
  assign rsp_o          = rsp_q;

  // Checks on the sequencer and the bump counter.
  `FSL_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
  `FSL_ASSERT_NEXT(a_exec_result, busy, result_valid_o && !busy,
                   "resolve cycle not followed by exactly one result")
  `FSL_ASSERT(a_result_not_busy, !(result_valid_o && $past(!busy)),
              "result without a preceding resolve cycle")
  `FSL_ASSERT(a_bump_range, bump_q <= BumpW'(SlotCount), "bump counter beyond slot count")

endmodule
